// ===== rtl/vsid_pkg.sv =====
package vsid_pkg;

  localparam int COUNT_W    = 16;
  localparam int INTERVAL_W = 8;
  localparam int AVG_W      = 32;
  localparam int EXP_W      = 20;
  localparam int STABLE_W   = 3;
  localparam int RATIO_W    = 24;
  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = EXP_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = EXP_W;
  localparam int STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED      = 1'd1;

  localparam logic [EXP_W-1:0]      EXPECTED_RESET = 20'd188160;
  localparam logic [RATIO_W-1:0]    RATIO_MAX      = 24'hFFFFFF;
  localparam logic [RATIO_W-1:0]    THRESH_Q16     = 24'd3277;
  localparam logic [RATIO_W-1:0]    LOW_LIMIT_Q16  = 24'd68813;
  localparam logic [RATIO_W:0]      HALF_Q16       = 25'd32768;
  localparam logic [INTERVAL_W-1:0] INTERVAL_ONE   = 8'd1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 8'd255;
  localparam logic [STABLE_W-1:0]   STABLE_MAX     = 3'd7;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_MUL,
    UOP_AVG_MAC,
    UOP_RATIO_LOAD,
    UOP_DECIDE,
    UOP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_BYPASS,
    COND_MAC_MORE,
    COND_DIV_MORE,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_item;
    logic bypass;
    logic mac_more;
    logic div_more;
    logic out_full;
  } seq_flags_t;

  localparam step_t STEP_ACCEPT    = 4'd0;
  localparam step_t STEP_CHECK     = 4'd1;
  localparam step_t STEP_MUL       = 4'd2;
  localparam step_t STEP_AVG_MAC   = 4'd3;
  localparam step_t STEP_RATIO_LD  = 4'd4;
  localparam step_t STEP_RATIO_DIV = 4'd5;
  localparam step_t STEP_DECIDE    = 4'd6;
  localparam step_t STEP_EMIT      = 4'd7;
  localparam step_t STEP_RETURN    = 4'd8;

  function automatic ctrl_word_t ucode_rom(step_t pc);
    ctrl_word_t w;
    case (pc)
      STEP_ACCEPT:    w = '{UOP_ACCEPT,     COND_NO_ITEM,  STEP_ACCEPT};
      STEP_CHECK:     w = '{UOP_NOP,        COND_BYPASS,   STEP_EMIT};
      STEP_MUL:       w = '{UOP_MUL,        COND_NEXT,     STEP_ACCEPT};
      STEP_AVG_MAC:   w = '{UOP_AVG_MAC,    COND_MAC_MORE, STEP_AVG_MAC};
      STEP_RATIO_LD:  w = '{UOP_RATIO_LOAD, COND_NEXT,     STEP_ACCEPT};
      STEP_RATIO_DIV: w = '{UOP_NOP,        COND_DIV_MORE, STEP_RATIO_DIV};
      STEP_DECIDE:    w = '{UOP_DECIDE,     COND_NEXT,     STEP_ACCEPT};
      STEP_EMIT:      w = '{UOP_EMIT,       COND_OUT_FULL, STEP_EMIT};
      STEP_RETURN:    w = '{UOP_NOP,        COND_ALWAYS,   STEP_ACCEPT};
      default:        w = '{UOP_NOP,        COND_ALWAYS,   STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/vsid_in_if.sv =====
interface vsid_in_if;
  import vsid_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] frame_count;

  modport source (output valid, output frame_count, input ready);
  modport sink (input valid, input frame_count, output ready);
endinterface

// ===== rtl/vsid_out_if.sv =====
interface vsid_out_if;
  import vsid_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] swap_interval;
  logic                  interval_changed;

  modport source (output valid, output swap_interval, output interval_changed, input ready);
  modport sink (input valid, input swap_interval, input interval_changed, output ready);
endinterface

// ===== rtl/vsid_div.sv =====
module vsid_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [vsid_pkg::DIV_NUM_W-1:0]  num,
  input  logic [vsid_pkg::DIV_DEN_W-1:0]  den,
  output logic                            last_iter,
  output logic [vsid_pkg::DIV_NUM_W-1:0]  quotient
);
  import vsid_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W:0]   trial;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NUM_W-1]} - {1'b0, den_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      cnt_nxt = DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt_r != '0) begin
      if (!trial[DIV_DEN_W]) begin
        rem_nxt = trial[DIV_DEN_W-1:0];
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_DEN_W-2:0], quo_r[DIV_NUM_W-1]};
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign last_iter = (cnt_r == DIV_CNT_W'(1));
  assign quotient  = quo_r;
endmodule

// ===== rtl/vsid_ucode_seq.sv =====
module vsid_ucode_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vsid_pkg::seq_flags_t   flags,
  output vsid_pkg::ctrl_word_t   ctrl
);
  import vsid_pkg::*;

  step_t pc_r, pc_nxt;
  logic  taken;

  always_comb begin
    ctrl = ucode_rom(pc_r);
    case (ctrl.cond)
      COND_NEXT:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_ITEM:  taken = flags.no_item;
      COND_BYPASS:   taken = flags.bypass;
      COND_MAC_MORE: taken = flags.mac_more;
      COND_DIV_MORE: taken = flags.div_more;
      COND_OUT_FULL: taken = flags.out_full;
      default:       taken = 1'b0;
    endcase
    pc_nxt = taken ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end
endmodule

// ===== rtl/vsync_swap_interval_detector_core.sv =====
// Channel  Dir  Payload                          Handshake
// in_ch    in   frame_count[15:0]                valid/ready, taken when both high
// out_ch   out  swap_interval[7:0], changed      valid/ready, taken when both high
// cfg      in   cfg_index[0], cfg_wdata[19:0]    cfg_we, no wait
//
// When detection runs, each item takes four multiply-accumulate steps for the
// average, then a 40-step serial division by the expected count; a bypassed
// item goes straight from the check step to the emit step.
// Synchronous active-low reset; the output register holds a result while
// out_ch.ready is low, and the sequencer waits at the emit step until it frees.
module vsync_swap_interval_detector_core #(
  parameter int WINDOW_FRAMES = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  vsid_in_if.sink                          in_ch,
  vsid_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [vsid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vsid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import vsid_pkg::*;

  localparam int PROD_W  = AVG_W + STABLE_W;
  localparam int MAC_W   = 18;
  localparam int RECIP_W = 2 * MAC_W;
  localparam int ACC_W   = 2 * RECIP_W;
  localparam int AVG_K   = PROD_W + $clog2(WINDOW_FRAMES);
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_K) + 64'(WINDOW_FRAMES) - 64'd1) / 64'(WINDOW_FRAMES));
  localparam logic [STABLE_W-1:0]  WIN_M1  = STABLE_W'(WINDOW_FRAMES - 1);
  localparam logic [STABLE_W-1:0]  WIN     = STABLE_W'(WINDOW_FRAMES);

  ctrl_word_t ctrl;
  seq_flags_t flags;

  logic                  en_r;
  logic [EXP_W-1:0]      expected_r;
  logic [COUNT_W-1:0]    count_r;
  logic [PROD_W-1:0]     prod_r;
  logic [1:0]            mac_r;
  logic [ACC_W-1:0]      acc_r;
  logic [AVG_W-1:0]      avg_r;
  logic [INTERVAL_W-1:0] last_cand_r;
  logic [STABLE_W-1:0]   stable_r;
  logic [INTERVAL_W-1:0] cur_r;
  logic                  changed_r;
  logic                  out_valid_r;
  logic [INTERVAL_W-1:0] out_interval_r;
  logic                  out_changed_r;

  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic                  div_last;
  logic [DIV_NUM_W-1:0]  div_quo;

  logic                  in_fire;
  logic                  emit_ok;
  logic [PROD_W-1:0]     sum;
  logic [MAC_W-1:0]      mac_a;
  logic [MAC_W-1:0]      mac_b;
  logic [RECIP_W-1:0]    mac_pp;
  logic [ACC_W-1:0]      mac_term;
  logic [AVG_W-1:0]      avg_new;
  logic [RATIO_W-1:0]    ratio;
  logic [RATIO_W:0]      rnd;
  logic [INTERVAL_W-1:0] cand;
  logic [RATIO_W-1:0]    base;
  logic [RATIO_W-1:0]    rem;
  logic [STABLE_W-1:0]   stable_inc;

  assign in_ch.ready = (ctrl.op == UOP_ACCEPT);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit_ok     = !out_valid_r || out_ch.ready;

  assign flags.no_item  = !in_fire;
  assign flags.bypass   = !en_r || (count_r == '0);
  assign flags.mac_more = !(&mac_r);
  assign flags.div_more = !div_last;
  assign flags.out_full = !emit_ok;

  vsid_ucode_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign sum = prod_r + {{STABLE_W{1'b0}}, count_r, {(AVG_W - COUNT_W){1'b0}}};

  always_comb begin
    mac_a  = mac_r[1] ? {{(2 * MAC_W - PROD_W){1'b0}}, sum[PROD_W-1:MAC_W]}
                      : sum[MAC_W-1:0];
    mac_b  = mac_r[0] ? AVG_RECIP[RECIP_W-1:MAC_W] : AVG_RECIP[MAC_W-1:0];
    mac_pp = {{MAC_W{1'b0}}, mac_a} * {{MAC_W{1'b0}}, mac_b};
    if (mac_r == '0) begin
      mac_term = {{RECIP_W{1'b0}}, mac_pp};
    end else if (&mac_r) begin
      mac_term = {mac_pp, {RECIP_W{1'b0}}};
    end else begin
      mac_term = {{MAC_W{1'b0}}, mac_pp, {MAC_W{1'b0}}};
    end
  end

  assign avg_new   = acc_r[AVG_K +: AVG_W];
  assign div_start = (ctrl.op == UOP_RATIO_LOAD);
  assign div_num   = {avg_new, {(DIV_NUM_W - AVG_W){1'b0}}};

  vsid_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .num       (div_num),
    .den       (expected_r),
    .last_iter (div_last),
    .quotient  (div_quo)
  );

  always_comb begin
    ratio = (div_quo[DIV_NUM_W-1:RATIO_W] != '0) ? RATIO_MAX : div_quo[RATIO_W-1:0];
    rnd   = {1'b0, ratio} + HALF_Q16;
    if (ratio < LOW_LIMIT_Q16) begin
      cand = INTERVAL_ONE;
      base = '0;
      rem  = '0;
    end else begin
      cand = rnd[RATIO_W] ? INTERVAL_MAX : rnd[RATIO_W-1:16];
      base = {cand, 16'h0000};
      rem  = (ratio >= base) ? (ratio - base) : (base - ratio);
    end
    stable_inc = (stable_r < STABLE_MAX) ? stable_r + 1'b1 : STABLE_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b1;
      expected_r  <= EXPECTED_RESET;
      avg_r       <= '0;
      mac_r       <= '0;
      last_cand_r <= INTERVAL_ONE;
      stable_r    <= '0;
      cur_r       <= INTERVAL_ONE;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DETECT_ENABLE: en_r       <= cfg_wdata[0];
          REG_EXPECTED:      expected_r <= cfg_wdata;
          default:           en_r       <= en_r;
        endcase
      end
      if (in_fire) begin
        changed_r <= 1'b0;
      end
      if (ctrl.op == UOP_AVG_MAC) begin
        mac_r <= mac_r + 1'b1;
      end
      if (ctrl.op == UOP_RATIO_LOAD) begin
        avg_r <= avg_new;
      end
      if (ctrl.op == UOP_DECIDE) begin
        if (rem <= THRESH_Q16 && cand != cur_r) begin
          if (cand == last_cand_r && stable_inc >= WIN) begin
            cur_r     <= cand;
            stable_r  <= '0;
            changed_r <= 1'b1;
          end else if (cand == last_cand_r) begin
            stable_r <= stable_inc;
          end else begin
            stable_r <= '0;
          end
          last_cand_r <= cand;
        end else begin
          stable_r <= '0;
        end
      end
      if (ctrl.op == UOP_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      count_r <= in_ch.frame_count;
    end
    if (ctrl.op == UOP_MUL) begin
      prod_r <= {{STABLE_W{1'b0}}, avg_r} * {{AVG_W{1'b0}}, WIN_M1};
    end
    if (ctrl.op == UOP_AVG_MAC) begin
      acc_r <= ((mac_r == '0) ? '0 : acc_r) + mac_term;
    end
    if (ctrl.op == UOP_EMIT && emit_ok) begin
      out_interval_r <= cur_r;
      out_changed_r  <= changed_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.swap_interval    = out_interval_r;
  assign out_ch.interval_changed = out_changed_r;
endmodule
